// File: rtl/core/vgs_pkg.sv
package vgs_pkg;

  // Field widths of the payload.
  localparam int COEF_W = 24;
  localparam int DIR_W  = 16;
  localparam int SPK_W  = 9;
  localparam int GAIN_W = 24;
  localparam int GOUT_W = 23;
  localparam int CFG_W  = 9;

  // Arithmetic widths: one product, and the sum of three products.
  localparam int PROD_W    = COEF_W + DIR_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int RND_SHIFT = 15;
  localparam int SHR_W     = SUM_W - RND_SHIFT;

  // A gain at or below this value counts as negative (-0.05 in Q8.16).
  localparam logic signed [GAIN_W-1:0] NEG_LIMIT = -24'sd3277;
  localparam logic [GOUT_W-1:0]        UNITY     = 23'd65536;

  // Configuration register indexes.
  localparam logic CFG_DIMENSION = 1'b0;
  localparam logic CFG_SET_COUNT = 1'b1;

  // Dimension code that selects speaker pairs; every other code means triplets.
  localparam logic [1:0] DIM_PAIRS = 2'd2;

  typedef logic signed [GAIN_W-1:0] gain_t;
  typedef logic [SPK_W-1:0]         spk_t;

  // One stored row of a set: speaker number and one inverse-matrix row.
  typedef struct packed {
    spk_t                      spk;
    logic signed [COEF_W-1:0]  cz;
    logic signed [COEF_W-1:0]  cy;
    logic signed [COEF_W-1:0]  cx;
  } vgs_row_t;

  // Bookkeeping that travels with a row through the gain pipeline.
  typedef struct packed {
    logic       first_row;
    logic       last_row;
    logic       first_set;
    logic [1:0] row;
    spk_t       spk;
  } vgs_tag_t;

endpackage

// File: rtl/core/vbap_gain_selection.sv
// Amplitude panning gain selection over a table of loudspeaker sets.
// Requests enter on start while busy is low. A request with in_action low
// writes one row (speaker number and inverse-matrix row) of one set and
// gives no result; busy stays low. A request with in_action
// high pans the direction in_dir_*: busy rises, every active set is read
// from the row memory one row per cycle and passed through a multiply stage,
// a round-and-saturate stage and a selection stage, and the winning set's
// gains are then sent, one result per dimension on consecutive cycles,
// each marked by out_valid for one cycle; out_last marks the final one.
// A pan holds busy while it makes count * dim row reads (count = active
// sets, dim = 2 or 3) through the single read port of the row memory, waits
// for the gain pipeline to drain, then sends dim results. An empty table
// gives one result with out_found low in the cycle after acceptance.
// Busy falls in the cycle after the last result. The receiver cannot stall.
// Configuration (cfg_we, cfg_index, cfg_data) is written while busy is low.
// Reset sets dimension 3 and set count 0; the row memory is not cleared and
// rows must be written before they take part in a pan.
module vbap_gain_selection import vgs_pkg::*; #(
  parameter int MAX_SETS     = 256,
  parameter int MAX_SPEAKERS = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_action,
  input  logic [7:0]                in_set_index,
  input  logic [1:0]                in_row_index,
  input  logic [SPK_W-1:0]          in_speaker_number,
  input  logic signed [COEF_W-1:0]  in_coef_x,
  input  logic signed [COEF_W-1:0]  in_coef_y,
  input  logic signed [COEF_W-1:0]  in_coef_z,
  input  logic signed [DIR_W-1:0]   in_dir_x,
  input  logic signed [DIR_W-1:0]   in_dir_y,
  input  logic signed [DIR_W-1:0]   in_dir_z,
  output logic                      out_valid,
  output logic [SPK_W-1:0]          out_speaker,
  output logic [GOUT_W-1:0]         out_gain,
  output logic                      out_found,
  output logic                      out_last,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  localparam int DEPTH  = MAX_SETS * 3;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(MAX_SETS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  s_r, s_nxt, count_r, count_nxt;
  logic [1:0]        j_r, j_nxt, out_idx_r, out_idx_nxt;
  logic              dim3_r, empty_r, empty_nxt;
  logic [1:0]        dim_r;
  logic [CNT_W-1:0]  set_count_r;
  logic [DIR_W-1:0]  dir_x_r, dir_y_r, dir_z_r;
  logic [1:0]        j_last;
  logic              accept, ram_we, ram_re;
  logic [ADDR_W-1:0] waddr, raddr;
  vgs_row_t          wrow, rrow;
  logic              v_rd_r;
  vgs_tag_t          tag_rd_r, tag_iss;
  logic              g_valid, pipe_busy;
  vgs_tag_t          g_tag;
  gain_t             g_gain;
  gain_t [2:0]       best_g;
  spk_t  [2:0]       best_spk;
  gain_t             sel_g;
  spk_t              sel_spk;
  logic              unity;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;
  assign j_last = dim3_r ? 2'd2 : 2'd1;

  // Configuration registers; the set count saturates at the table size.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r       <= 2'd3;
      set_count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIMENSION: dim_r <= cfg_data[1:0];
        CFG_SET_COUNT: begin
          set_count_r <= (int'(cfg_data) > MAX_SETS) ? CNT_W'(MAX_SETS)
                                                     : CNT_W'(cfg_data);
        end
        default: ;
      endcase
    end
  end

  // Row writes go straight into the memory.
  assign ram_we = accept && !in_action && (int'(in_set_index) < MAX_SETS)
                  && (in_row_index != 2'd3);
  assign waddr  = (ADDR_W'(in_set_index) << 1) + ADDR_W'(in_set_index)
                  + ADDR_W'(in_row_index);
  assign wrow   = '{spk: in_speaker_number, cz: in_coef_z, cy: in_coef_y, cx: in_coef_x};

  // The scan reads one row per cycle.
  assign ram_re = (state_r == ST_SCAN);
  assign raddr  = (ADDR_W'(s_r) << 1) + ADDR_W'(s_r) + ADDR_W'(j_r);
  assign tag_iss = '{first_row: (j_r == 2'd0), last_row: (j_r == j_last),
                     first_set: (s_r == '0), row: j_r, spk: '0};

  vgs_ram #(
    .WIDTH ($bits(vgs_row_t)),
    .DEPTH (DEPTH)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wrow),
    .re    (ram_re),
    .raddr (raddr),
    .rdata (rrow)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_rd_r <= 1'b0;
    end else begin
      v_rd_r <= ram_re;
    end
    tag_rd_r <= tag_iss;
  end

  vgs_row_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v_rd_r),
    .in_tag    (tag_rd_r),
    .in_row    (rrow),
    .dir_x     (dir_x_r),
    .dir_y     (dir_y_r),
    .dir_z     (dir_z_r),
    .dim3      (dim3_r),
    .out_valid (g_valid),
    .out_tag   (g_tag),
    .out_gain  (g_gain),
    .pipe_busy (pipe_busy)
  );

  vgs_select u_select (
    .clk      (clk),
    .in_valid (g_valid),
    .in_tag   (g_tag),
    .in_gain  (g_gain),
    .best_g   (best_g),
    .best_spk (best_spk)
  );

  // Sequencer: scan the sets, wait for the pipeline to empty, send results.
  always_comb begin
    state_nxt   = state_r;
    s_nxt       = s_r;
    j_nxt       = j_r;
    count_nxt   = count_r;
    empty_nxt   = empty_r;
    out_idx_nxt = out_idx_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_action) begin
          s_nxt       = '0;
          j_nxt       = 2'd0;
          out_idx_nxt = 2'd0;
          count_nxt   = set_count_r;
          empty_nxt   = (set_count_r == '0);
          state_nxt   = (set_count_r == '0) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (j_r == j_last) begin
          j_nxt = 2'd0;
          s_nxt = s_r + 1'b1;
          if (s_r == count_r - 1'b1) begin
            state_nxt = ST_DRAIN;
          end
        end else begin
          j_nxt = j_r + 2'd1;
        end
      end
      ST_DRAIN: begin
        if (!v_rd_r && !pipe_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_idx_nxt = out_idx_r + 2'd1;
        if (empty_r || (out_idx_r == j_last)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      s_r       <= '0;
      j_r       <= 2'd0;
      count_r   <= '0;
      empty_r   <= 1'b0;
      out_idx_r <= 2'd0;
      dim3_r    <= 1'b1;
    end else begin
      state_r   <= state_nxt;
      s_r       <= s_nxt;
      j_r       <= j_nxt;
      count_r   <= count_nxt;
      empty_r   <= empty_nxt;
      out_idx_r <= out_idx_nxt;
      if (accept && in_action) begin
        dim3_r <= (dim_r != DIM_PAIRS);
      end
    end
  end

  // The direction is held for the whole pan.
  always_ff @(posedge clk) begin
    if (accept && in_action) begin
      dir_x_r <= in_dir_x;
      dir_y_r <= in_dir_y;
      dir_z_r <= in_dir_z;
    end
  end

  // Result formatting: unity fallback, clamping, speaker number check.
  always_comb begin
    unity   = ($signed(best_g[0]) <= 0) && ($signed(best_g[1]) <= 0)
              && ($signed(best_g[2]) <= 0);
    sel_g   = best_g[out_idx_r];
    sel_spk = best_spk[out_idx_r];
    out_valid = (state_r == ST_OUT);
    out_found = !empty_r;
    out_last  = empty_r || (out_idx_r == j_last);
    if (empty_r) begin
      out_gain    = '0;
      out_speaker = '0;
    end else begin
      if (unity) begin
        out_gain = UNITY;
      end else if (sel_g[GAIN_W-1]) begin
        out_gain = '0;
      end else begin
        out_gain = sel_g[GOUT_W-1:0];
      end
      if ((sel_spk == '0) || (int'(sel_spk) > MAX_SPEAKERS)) begin
        out_speaker = '0;
      end else begin
        out_speaker = sel_spk;
      end
    end
  end

  // Memory reads belong to a pan and writes only happen while idle.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("row memory read and written in the same cycle");

  // Results leave only once the gain pipeline is empty.
  a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!v_rd_r && !pipe_busy))
    else $error("result sent while rows still in flight");

  // The final result of a pan releases the block.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !busy)
    else $error("block still busy after the last result");

  // An empty table gives exactly one result.
  a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> out_last)
    else $error("empty-table result not marked last");

endmodule

// File: rtl/core/vgs_ram.sv
module vgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, single registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/vgs_row_gain.sv
module vgs_row_gain import vgs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  vgs_tag_t                 in_tag,
  input  vgs_row_t                 in_row,
  input  logic signed [DIR_W-1:0]  dir_x,
  input  logic signed [DIR_W-1:0]  dir_y,
  input  logic signed [DIR_W-1:0]  dir_z,
  input  logic                     dim3,
  output logic                     out_valid,
  output vgs_tag_t                 out_tag,
  output gain_t                    out_gain,
  output logic                     pipe_busy
);

  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;
  logic signed [PROD_W-1:0] pz;
  logic                     v_mul_r;
  vgs_tag_t                 tag_mul_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SHR_W-1:0]  shr;
  logic                     sat_hi, sat_lo;
  gain_t                    gain_nxt;

  // The z product only takes part for triplets.
  assign pz = in_row.cz * dir_z;

  // Stage one: the three products of the row with the direction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_mul_r <= 1'b0;
    end else begin
      v_mul_r <= in_valid;
    end
    p0_r <= in_row.cx * dir_x;
    p1_r <= in_row.cy * dir_y;
    p2_r <= dim3 ? pz : '0;
    tag_mul_r <= '{first_row: in_tag.first_row, last_row: in_tag.last_row,
                   first_set: in_tag.first_set, row: in_tag.row, spk: in_row.spk};
  end

  // Stage two: sum, round half up, saturate to the gain range.
  always_comb begin
    sum    = SUM_W'(p0_r) + SUM_W'(p1_r) + SUM_W'(p2_r)
             + SUM_W'(1 << (RND_SHIFT - 1));
    shr    = sum[SUM_W-1:RND_SHIFT];
    sat_hi = !shr[SHR_W-1] && (|shr[SHR_W-2:GAIN_W-1]);
    sat_lo = shr[SHR_W-1] && !(&shr[SHR_W-2:GAIN_W-1]);
    if (sat_hi) begin
      gain_nxt = {1'b0, {(GAIN_W-1){1'b1}}};
    end else if (sat_lo) begin
      gain_nxt = {1'b1, {(GAIN_W-1){1'b0}}};
    end else begin
      gain_nxt = shr[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_mul_r;
    end
    out_gain <= gain_nxt;
    out_tag  <= tag_mul_r;
  end

  assign pipe_busy = v_mul_r | out_valid;

endmodule

// File: rtl/core/vgs_select.sv
module vgs_select import vgs_pkg::*; (
  input  logic           clk,
  input  logic           in_valid,
  input  vgs_tag_t       in_tag,
  input  gain_t          in_gain,
  output gain_t [2:0]    best_g,
  output spk_t  [2:0]    best_spk
);

  gain_t [2:0] cur_g_r,   g_nxt;
  spk_t  [2:0] cur_spk_r, spk_nxt;
  gain_t       cur_small_r, small_nxt, best_small_r;
  logic  [1:0] cur_neg_r,   neg_nxt,   best_neg_r;
  logic        take;

  // Fold the incoming row into the running set, then compare on its last row.
  always_comb begin
    g_nxt   = in_tag.first_row ? '0 : cur_g_r;
    spk_nxt = in_tag.first_row ? '0 : cur_spk_r;
    g_nxt[in_tag.row]   = in_gain;
    spk_nxt[in_tag.row] = in_tag.spk;
    if (in_tag.first_row || ($signed(in_gain) < $signed(cur_small_r))) begin
      small_nxt = in_gain;
    end else begin
      small_nxt = cur_small_r;
    end
    neg_nxt = (in_tag.first_row ? 2'd0 : cur_neg_r)
              + {1'b0, ($signed(in_gain) <= $signed(NEG_LIMIT))};
    take = in_tag.first_set || (neg_nxt < best_neg_r)
           || ((neg_nxt == best_neg_r) && ($signed(small_nxt) > $signed(best_small_r)));
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      cur_g_r     <= g_nxt;
      cur_spk_r   <= spk_nxt;
      cur_small_r <= small_nxt;
      cur_neg_r   <= neg_nxt;
      if (in_tag.last_row && take) begin
        best_g       <= g_nxt;
        best_spk     <= spk_nxt;
        best_small_r <= small_nxt;
        best_neg_r   <= neg_nxt;
      end
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import vgs_pkg::*;

  localparam int NUM_SETS      = 256;
  localparam int NUM_SPEAKERS  = 256;
  localparam int LOADED_SETS   = 16;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 16;

  // Gain arithmetic constants (Q8.16).
  localparam int GAIN_HI   = 8388607;
  localparam int GAIN_LO   = -8388608;
  localparam int START_LOW = 1000 * 65536;
  localparam int NEG_GAIN  = -3277;

  localparam logic signed [COEF_W-1:0] COEF_ONE = 24'sd65536;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 24'sh7fffff;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 24'sh800000;
  localparam logic signed [DIR_W-1:0]  DIR_MAX  = 16'sh7fff;
  localparam logic signed [DIR_W-1:0]  DIR_MIN  = 16'sh8000;
  localparam logic signed [DIR_W-1:0]  DIR_HALF = 16'sd16384;

  // Request kinds and dimension codes.
  localparam logic       ACT_WRITE    = 1'b0;
  localparam logic       ACT_PAN      = 1'b1;
  localparam logic [1:0] DIM_TRIPLETS = 2'd3;
  localparam logic [1:0] DIM_ODD_ZERO = 2'd0;
  localparam logic [1:0] DIM_ODD_ONE  = 2'd1;
  localparam logic [1:0] ROW_IGNORED  = 2'd3;

  typedef struct packed {
    logic                     action;
    logic [7:0]               set_idx;
    logic [1:0]               row;
    spk_t                     spk;
    logic signed [COEF_W-1:0] cx;
    logic signed [COEF_W-1:0] cy;
    logic signed [COEF_W-1:0] cz;
    logic signed [DIR_W-1:0]  dx;
    logic signed [DIR_W-1:0]  dy;
    logic signed [DIR_W-1:0]  dz;
  } request_t;

  typedef struct packed {
    spk_t              speaker;
    logic [GOUT_W-1:0] gain;
    logic              found;
    logic              last;
  } gain_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_action;
  logic [7:0]               in_set_index;
  logic [1:0]               in_row_index;
  logic [SPK_W-1:0]         in_speaker_number;
  logic signed [COEF_W-1:0] in_coef_x;
  logic signed [COEF_W-1:0] in_coef_y;
  logic signed [COEF_W-1:0] in_coef_z;
  logic signed [DIR_W-1:0]  in_dir_x;
  logic signed [DIR_W-1:0]  in_dir_y;
  logic signed [DIR_W-1:0]  in_dir_z;
  logic                     out_valid;
  logic [SPK_W-1:0]         out_speaker;
  logic [GOUT_W-1:0]        out_gain;
  logic                     out_found;
  logic                     out_last;
  logic                     cfg_we;
  logic                     cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  // Shadow copy of the speaker-set table and the registers.
  logic signed [COEF_W-1:0] coef_mem [NUM_SETS][3][3];
  spk_t                     spk_mem  [NUM_SETS][3];
  logic [1:0]               model_dim;
  logic [CFG_W-1:0]         model_count;

  gain_result_t expected_gains[$];

  bit gaps_on;
  int err_count;
  int pans_sent;
  int writes_sent;
  int cfg_writes;
  int results_seen;

  vbap_gain_selection #(
    .MAX_SETS     (NUM_SETS),
    .MAX_SPEAKERS (NUM_SPEAKERS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_set_index      (in_set_index),
    .in_row_index      (in_row_index),
    .in_speaker_number (in_speaker_number),
    .in_coef_x         (in_coef_x),
    .in_coef_y         (in_coef_y),
    .in_coef_z         (in_coef_z),
    .in_dir_x          (in_dir_x),
    .in_dir_y          (in_dir_y),
    .in_dir_z          (in_dir_z),
    .out_valid         (out_valid),
    .out_speaker       (out_speaker),
    .out_gain          (out_gain),
    .out_found         (out_found),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Runaway guard.
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  // One row gain: dot product, round half up by 15 bits, saturate to Q8.16.
  function automatic int row_gain(int s, int r, int dimv, longint dx, longint dy, longint dz);
    longint acc;
    longint rnd;
    acc = longint'(coef_mem[s][r][0]) * dx + longint'(coef_mem[s][r][1]) * dy;
    if (dimv == 3) acc += longint'(coef_mem[s][r][2]) * dz;
    rnd = (acc + 64'sd16384) >>> 15;
    if (rnd > GAIN_HI) rnd = GAIN_HI;
    if (rnd < GAIN_LO) rnd = GAIN_LO;
    return int'(rnd);
  endfunction

  // Update the shadow table, or work out the gains that a pan request yields.
  task automatic predict_request(input request_t r);
    int           dimv;
    int           cnt;
    int           best;
    int           best_neg;
    int           best_low;
    int           neg;
    int           low;
    int           g[3];
    int           best_g[3];
    gain_result_t res;
    if (r.action == ACT_WRITE) begin
      writes_sent++;
      if (r.row != ROW_IGNORED && int'(r.set_idx) < NUM_SETS) begin
        spk_mem[r.set_idx][r.row]     = r.spk;
        coef_mem[r.set_idx][r.row][0] = r.cx;
        coef_mem[r.set_idx][r.row][1] = r.cy;
        coef_mem[r.set_idx][r.row][2] = r.cz;
      end
      return;
    end
    pans_sent++;
    dimv = (model_dim == DIM_PAIRS) ? 2 : 3;
    cnt  = (model_count > NUM_SETS) ? NUM_SETS : int'(model_count);
    if (cnt == 0) begin
      res = '{speaker: '0, gain: '0, found: 1'b0, last: 1'b1};
      expected_gains = {expected_gains, res};
      return;
    end
    best     = 0;
    best_neg = 0;
    best_low = 0;
    best_g   = '{0, 0, 0};
    for (int s = 0; s < cnt; s++) begin
      g   = '{0, 0, 0};
      low = START_LOW;
      neg = 0;
      for (int j = 0; j < dimv; j++) begin
        g[j] = row_gain(s, j, dimv, r.dx, r.dy, r.dz);
        if (g[j] < low) low = g[j];
        if (g[j] <= NEG_GAIN) neg++;
      end
      if (s == 0 || neg < best_neg || (neg == best_neg && low > best_low)) begin
        best     = s;
        best_neg = neg;
        best_low = low;
        best_g   = g;
      end
    end
    // A set with no positive gain falls back to unity on every speaker.
    if (best_g[0] <= 0 && best_g[1] <= 0 && best_g[2] <= 0) best_g = '{65536, 65536, 65536};
    for (int j = 0; j < dimv; j++) begin
      res.speaker = (spk_mem[best][j] == 0 || spk_mem[best][j] > NUM_SPEAKERS) ?
                    '0 : spk_mem[best][j];
      res.gain    = (best_g[j] < 0) ? '0 : best_g[j][GOUT_W-1:0];
      res.found   = 1'b1;
      res.last    = (j + 1 == dimv);
      expected_gains = {expected_gains, res};
    end
  endtask

  // Compare every strobed result with the oldest expected one.
  always @(posedge clk) begin
    gain_result_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_gains.size() == 0) begin
        $error("unexpected result: speaker %0d gain %0d found %0d last %0d",
               out_speaker, out_gain, out_found, out_last);
        err_count++;
      end else begin
        want = expected_gains.pop_front();
        if (out_speaker !== want.speaker) begin
          $error("out_speaker: expected %0d, got %0d", want.speaker, out_speaker);
          err_count++;
        end
        if (out_gain !== want.gain) begin
          $error("out_gain: expected %0d, got %0d", want.gain, out_gain);
          err_count++;
        end
        if (out_found !== want.found) begin
          $error("out_found: expected %0d, got %0d", want.found, out_found);
          err_count++;
        end
        if (out_last !== want.last) begin
          $error("out_last: expected %0d, got %0d", want.last, out_last);
          err_count++;
        end
      end
    end
  end

  // Random values on the request fields while no request is offered.
  task automatic drive_noise();
    in_action         = 1'($urandom);
    in_set_index      = 8'($urandom);
    in_row_index      = 2'($urandom);
    in_speaker_number = SPK_W'($urandom);
    in_coef_x         = COEF_W'($urandom);
    in_coef_y         = COEF_W'($urandom);
    in_coef_z         = COEF_W'($urandom);
    in_dir_x          = DIR_W'($urandom);
    in_dir_y          = DIR_W'($urandom);
    in_dir_z          = DIR_W'($urandom);
  endtask

  // Offer one request after a random gap and hold it until busy is low at an edge.
  task automatic send_request(input request_t r);
    int gap;
    int pick;
    gap = 0;
    if (gaps_on) begin
      pick = $urandom_range(99);
      if (pick < 60) gap = 0;
      else if (pick < 90) gap = $urandom_range(3, 1);
      else gap = $urandom_range(40, 8);
    end
    repeat (gap) begin
      @(negedge clk);
      start = 1'b0;
      drive_noise();
    end
    @(negedge clk);
    in_action         = r.action;
    in_set_index      = r.set_idx;
    in_row_index      = r.row;
    in_speaker_number = r.spk;
    in_coef_x         = r.cx;
    in_coef_y         = r.cy;
    in_coef_z         = r.cz;
    in_dir_x          = r.dx;
    in_dir_y          = r.dy;
    in_dir_z          = r.dz;
    start             = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(r);
  endtask

  task automatic write_row(input logic [7:0] set_idx, input logic [1:0] row, input spk_t spk,
                           input logic signed [COEF_W-1:0] cx,
                           input logic signed [COEF_W-1:0] cy,
                           input logic signed [COEF_W-1:0] cz);
    request_t r;
    r = '{action: ACT_WRITE, set_idx: set_idx, row: row, spk: spk, cx: cx, cy: cy, cz: cz,
          dx: DIR_W'($urandom), dy: DIR_W'($urandom), dz: DIR_W'($urandom)};
    send_request(r);
  endtask

  task automatic pan_dir(input logic signed [DIR_W-1:0] dx, input logic signed [DIR_W-1:0] dy,
                         input logic signed [DIR_W-1:0] dz);
    request_t r;
    r = '{action: ACT_PAN, set_idx: 8'($urandom), row: 2'($urandom), spk: SPK_W'($urandom),
          cx: COEF_W'($urandom), cy: COEF_W'($urandom), cz: COEF_W'($urandom),
          dx: dx, dy: dy, dz: dz};
    send_request(r);
  endtask

  // Drop start and wait until the block has drained every pending result.
  task automatic wait_idle();
    @(negedge clk);
    start = 1'b0;
    drive_noise();
    while (expected_gains.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [CFG_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    if (idx == CFG_DIMENSION) model_dim = val[1:0];
    else model_count = val;
    cfg_writes++;
    @(negedge clk);
    cfg_we   = 1'b0;
    cfg_data = '0;
  endtask

  // Coefficients: simple fractions, moderate values, raw bits, and the extremes.
  function automatic logic signed [COEF_W-1:0] rand_coef();
    int pick;
    int v;
    pick = $urandom_range(9);
    if (pick < 4) begin
      v = 16384 << $urandom_range(2);
      if ($urandom_range(1)) v = -v;
      if ($urandom_range(4) == 0) v = 0;
    end else if (pick < 8) begin
      v = int'($urandom_range(524288)) - 262144;
    end else if (pick == 8) begin
      v = $urandom;
    end else begin
      v = $urandom_range(1) ? GAIN_HI : GAIN_LO;
    end
    return v[COEF_W-1:0];
  endfunction

  function automatic logic signed [DIR_W-1:0] rand_dir();
    int pick;
    int v;
    pick = $urandom_range(9);
    if (pick < 6) v = $urandom;
    else if (pick == 6) v = 32767;
    else if (pick == 7) v = -32768;
    else if (pick == 8) v = 0;
    else v = $urandom_range(1) ? 23170 : -23170;
    return v[DIR_W-1:0];
  endfunction

  // Mostly valid speaker numbers, sometimes raw bits (possibly zero or out of range).
  function automatic spk_t rand_speaker();
    if ($urandom_range(9) != 0) return spk_t'($urandom_range(NUM_SPEAKERS, 1));
    return spk_t'($urandom);
  endfunction

  // Pans with no active set, around an ignored row write.
  task automatic test_empty_table();
    pan_dir(DIR_MAX, DIR_MIN, '0);
    write_row(8'd5, ROW_IGNORED, 9'd4, COEF_ONE, COEF_ONE, COEF_ONE);
    pan_dir(DIR_MIN, DIR_MAX, DIR_MAX);
  endtask

  // The first sets get every row written; set counts never reach past them.
  task automatic test_load_table();
    for (int s = 0; s < LOADED_SETS; s++) begin
      for (int r = 0; r < 3; r++) begin
        write_row(s[7:0], r[1:0], rand_speaker(), rand_coef(), rand_coef(), rand_coef());
      end
    end
  endtask

  task automatic test_directed();
    // Identity matrix; default dimension is triplets.
    write_cfg(CFG_SET_COUNT, 9'd1);
    write_row(8'd0, 2'd0, 9'd1, COEF_ONE, '0, '0);
    write_row(8'd0, 2'd1, 9'd2, '0, COEF_ONE, '0);
    write_row(8'd0, 2'd2, 9'd3, '0, '0, COEF_ONE);
    pan_dir(DIR_MAX, '0, '0);
    // No positive gain: unity fallback.
    pan_dir(DIR_MIN, '0, '0);
    // Exact halves round up; speaker numbers zero and out of range.
    write_row(8'd0, 2'd0, 9'd0, 24'sd1, '0, '0);
    write_row(8'd0, 2'd1, 9'd511, -24'sd1, '0, '0);
    write_row(8'd0, 2'd2, 9'd256, '0, '0, COEF_ONE);
    pan_dir(DIR_HALF, '0, '0);
    // Saturation in both directions.
    write_row(8'd0, 2'd0, 9'd7, COEF_MAX, COEF_MAX, COEF_MAX);
    write_row(8'd0, 2'd1, 9'd8, COEF_MIN, COEF_MIN, COEF_MIN);
    pan_dir(DIR_MAX, DIR_MAX, DIR_MAX);
    pan_dir(DIR_MIN, DIR_MIN, DIR_MIN);
    // Two identical sets: the lower index wins the tie.
    write_cfg(CFG_SET_COUNT, 9'd2);
    for (int r = 0; r < 3; r++) begin
      write_row(8'd0, r[1:0], spk_t'(r + 1), (r == 0) ? COEF_ONE : '0,
                (r == 1) ? COEF_ONE : '0, (r == 2) ? COEF_ONE : '0);
      write_row(8'd1, r[1:0], spk_t'(r + 10), (r == 0) ? COEF_ONE : '0,
                (r == 1) ? COEF_ONE : '0, (r == 2) ? COEF_ONE : '0);
    end
    pan_dir('0, DIR_MAX, '0);
    // Pairs, then the odd dimension codes that act as triplets.
    write_cfg(CFG_DIMENSION, CFG_W'(DIM_PAIRS));
    pan_dir('0, DIR_MAX, DIR_MIN);
    write_cfg(CFG_DIMENSION, CFG_W'(DIM_ODD_ZERO));
    pan_dir(DIR_MAX, DIR_MAX, DIR_MAX);
    write_cfg(CFG_DIMENSION, CFG_W'(DIM_ODD_ONE));
    pan_dir(DIR_MIN, DIR_MAX, DIR_HALF);
    // Every loaded set takes part at once.
    write_cfg(CFG_DIMENSION, CFG_W'(DIM_TRIPLETS));
    write_cfg(CFG_SET_COUNT, CFG_W'(LOADED_SETS));
    pan_dir(rand_dir(), rand_dir(), rand_dir());
    pan_dir(rand_dir(), rand_dir(), rand_dir());
  endtask

  // Phases of mixed row writes and pans under random register settings.
  task automatic test_random();
    int         pick;
    int         n;
    logic [1:0] dim_code;
    logic [1:0] row;
    logic [7:0] set_idx;
    logic [8:0] count;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      gaps_on = ($urandom_range(3) != 0);
      pick = $urandom_range(9);
      if (pick < 4) dim_code = DIM_PAIRS;
      else if (pick < 8) dim_code = DIM_TRIPLETS;
      else if (pick == 8) dim_code = DIM_ODD_ZERO;
      else dim_code = DIM_ODD_ONE;
      write_cfg(CFG_DIMENSION, {7'd0, dim_code});
      pick = $urandom_range(19);
      if (pick < 10) count = 9'($urandom_range(8, 1));
      else if (pick < 16) count = 9'($urandom_range(LOADED_SETS, 9));
      else if (pick < 18) count = '0;
      else count = 9'(LOADED_SETS);
      write_cfg(CFG_SET_COUNT, count);
      n = PHASE_ITEMS;
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(99) < 45) begin
          pan_dir(rand_dir(), rand_dir(), rand_dir());
        end else begin
          row     = ($urandom_range(9) == 0) ? ROW_IGNORED : 2'($urandom_range(2));
          set_idx = ($urandom_range(9) < 7) ? 8'($urandom_range(15)) : 8'($urandom);
          write_row(set_idx, row, rand_speaker(), rand_coef(), rand_coef(), rand_coef());
          // Ignored writes do not count as items.
          if (row == ROW_IGNORED) n++;
        end
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_DIMENSION;
    cfg_data     = '0;
    model_dim    = DIM_TRIPLETS;
    model_count  = '0;
    gaps_on      = 1'b1;
    err_count    = 0;
    pans_sent    = 0;
    writes_sent  = 0;
    cfg_writes   = 0;
    results_seen = 0;
    drive_noise();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_load_table();
    test_directed();
    test_random();

    // Drain, then leave room for any stray result.
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d pans and %0d row writes across %0d register writes.",
             pans_sent, writes_sent, cfg_writes);
    $display("Compared %0d results; %0d mismatches.", results_seen, err_count);
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
